// File: design/tssg_pkg.sv
// Shared constants and types of the triangle scanline span generator.
package tssg_pkg;

    localparam int COORD_W    = 16;
    localparam int ROW_W      = COORD_W + 2;
    localparam int COLOR_W    = 24;
    localparam int STEP_W     = 9;
    localparam int STEP_RESET = 16;
    localparam int MAX_SPANS  = 64;
    localparam int CNT_W      = $clog2(MAX_SPANS + 1);
    localparam int DIV_CNT_W  = $clog2(COORD_W);
    localparam int QUEUE_AW   = 1;
    localparam int QUEUE_CW   = QUEUE_AW + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] t_x;
        logic signed [COORD_W-1:0] t_y;
        logic signed [COORD_W-1:0] m_x;
        logic signed [COORD_W-1:0] m_y;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic [COLOR_W-1:0]        color;
        logic                      degen;
        logic                      flat_top;
        logic                      flat_bot;
    } tri_t;

    typedef struct packed {
        logic valid;
        tri_t data;
    } tri_link_t;

endpackage

// File: design/tssg_front.sv
// Front end: accept triangles, sort vertices, classify, and queue them.
module tssg_front
    import tssg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [COORD_W-1:0] vertex_a_x,
    input  logic signed [COORD_W-1:0] vertex_a_y,
    input  logic signed [COORD_W-1:0] vertex_b_x,
    input  logic signed [COORD_W-1:0] vertex_b_y,
    input  logic signed [COORD_W-1:0] vertex_c_x,
    input  logic signed [COORD_W-1:0] vertex_c_y,
    input  logic [COLOR_W-1:0]        tri_color,
    output tri_link_t                 link,
    input  logic                      link_pop
);

    logic signed [COORD_W-1:0] xs [3];
    logic signed [COORD_W-1:0] ys [3];
    logic [1:0]                imax;
    logic [1:0]                imin;
    logic [1:0]                imid;
    logic signed [COORD_W-1:0] lo_x;
    logic signed [COORD_W-1:0] hi_x;
    tri_t                      cls;

    tri_t                queue_reg [2];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    always_comb
    begin
        xs[0] = vertex_a_x;
        xs[1] = vertex_b_x;
        xs[2] = vertex_c_x;
        ys[0] = vertex_a_y;
        ys[1] = vertex_b_y;
        ys[2] = vertex_c_y;
        imax = 2'd0;
        imin = 2'd0;
        if (ys[1] > ys[imax])
        begin
            imax = 2'd1;
        end
        if (ys[2] > ys[imax])
        begin
            imax = 2'd2;
        end
        if (ys[1] < ys[imin])
        begin
            imin = 2'd1;
        end
        if (ys[2] < ys[imin])
        begin
            imin = 2'd2;
        end
        imid = 2'd3 - imax - imin;
        lo_x = xs[0];
        hi_x = xs[0];
        for (int i = 1; i < 3; i++)
        begin
            if (xs[i] < lo_x)
            begin
                lo_x = xs[i];
            end
            if (xs[i] > hi_x)
            begin
                hi_x = xs[i];
            end
        end
        cls.color = tri_color;
        if (imax == imin)
        begin
            cls.t_x      = xs[0];
            cls.t_y      = ys[0];
            cls.m_x      = hi_x;
            cls.m_y      = ys[0];
            cls.b_x      = lo_x;
            cls.b_y      = ys[0];
            cls.degen    = 1'b1;
            cls.flat_top = 1'b0;
            cls.flat_bot = 1'b1;
        end
        else
        begin
            cls.t_x      = xs[imax];
            cls.t_y      = ys[imax];
            cls.m_x      = xs[imid];
            cls.m_y      = ys[imid];
            cls.b_x      = xs[imin];
            cls.b_y      = ys[imin];
            cls.degen    = 1'b0;
            cls.flat_top = (ys[imid] == ys[imax]);
            cls.flat_bot = (ys[imid] == ys[imin]);
        end
    end

    assign full       = (count_reg == QUEUE_CW'(2));
    assign do_push    = push && !full;
    assign do_pop     = link_pop && (count_reg != '0);
    assign link.valid = (count_reg != '0);
    assign link.data  = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!do_push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/tssg_back.sv
// Back end: walk scanlines, interpolate both edges with serial dividers, emit spans.
module tssg_back
    import tssg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  tri_link_t                 link,
    output logic                      link_pop,
    input  logic [STEP_W-1:0]         row_step,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [COORD_W-1:0] span_row,
    output logic signed [COORD_W-1:0] span_left,
    output logic signed [COORD_W-1:0] span_right,
    output logic [COLOR_W-1:0]        span_color,
    output logic                      last_span,
    output logic                      cut_short
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;
    localparam logic [2:0] S_ROW   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_LAST  = 3'd6;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    tri_t                      tri_reg;
    logic signed [ROW_W-1:0]   row_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      drop_reg;
    logic [DIV_CNT_W-1:0]      div_cnt_reg;

    logic signed [COORD_W-1:0] lo_x_reg [2];
    logic [COORD_W-1:0]        d_reg    [2];
    logic [COORD_W-1:0]        m_reg    [2];
    logic [COORD_W-1:0]        t_reg    [2];
    logic                      neg_reg  [2];
    logic [COORD_W-1:0]        r_reg    [2];
    logic [COORD_W-1:0]        q_reg    [2];

    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] out_row_reg;
    logic signed [COORD_W-1:0] out_left_reg;
    logic signed [COORD_W-1:0] out_right_reg;
    logic [COLOR_W-1:0]        out_color_reg;
    logic                      out_last_reg;
    logic                      out_cut_reg;

    logic                      can_emit;
    logic                      load_out;
    logic signed [ROW_W-1:0]   emit_row;
    logic signed [ROW_W-1:0]   emit_a;
    logic signed [ROW_W-1:0]   emit_b;
    logic                      emit_last;

    logic [STEP_W-1:0]         step;
    logic signed [ROW_W-1:0]   b_y_ext;
    logic signed [ROW_W-1:0]   m_y_ext;
    logic                      upper;
    logic signed [COORD_W-1:0] hi_x_s [2];
    logic signed [COORD_W-1:0] hi_y_s [2];
    logic signed [COORD_W-1:0] lo_x_s [2];
    logic signed [COORD_W-1:0] lo_y_s [2];
    logic signed [COORD_W:0]   dx_s   [2];
    logic [COORD_W:0]          dy_s   [2];
    logic [COORD_W:0]          mag_s  [2];
    logic signed [ROW_W-1:0]   t_s    [2];
    logic [2*COORD_W-1:0]      prod   [2];
    logic [COORD_W:0]          rs     [2];
    logic                      ge     [2];
    logic [COORD_W:0]          rs_sub [2];
    logic                      rnd    [2];
    logic [COORD_W:0]          qmag   [2];
    logic signed [ROW_W-1:0]   xv     [2];

    assign step     = (row_step == '0) ? STEP_W'(1) : row_step;
    assign b_y_ext  = ROW_W'(tri_reg.b_y);
    assign m_y_ext  = ROW_W'(tri_reg.m_y);
    assign upper    = (row_reg > m_y_ext);
    assign can_emit = !out_valid_reg || pop;
    assign link_pop = (state_reg == S_IDLE) && link.valid;

    always_comb
    begin
        hi_x_s[0] = tri_reg.t_x;
        hi_y_s[0] = tri_reg.t_y;
        lo_x_s[0] = tri_reg.b_x;
        lo_y_s[0] = tri_reg.b_y;
        hi_x_s[1] = upper ? tri_reg.t_x : tri_reg.m_x;
        hi_y_s[1] = upper ? tri_reg.t_y : tri_reg.m_y;
        lo_x_s[1] = upper ? tri_reg.m_x : tri_reg.b_x;
        lo_y_s[1] = upper ? tri_reg.m_y : tri_reg.b_y;
        for (int i = 0; i < 2; i++)
        begin
            dx_s[i]   = (COORD_W+1)'(hi_x_s[i]) - (COORD_W+1)'(lo_x_s[i]);
            dy_s[i]   = (COORD_W+1)'(hi_y_s[i]) - (COORD_W+1)'(lo_y_s[i]);
            mag_s[i]  = dx_s[i][COORD_W] ? (COORD_W+1)'(-dx_s[i]) : dx_s[i];
            t_s[i]    = row_reg - ROW_W'(lo_y_s[i]);
            prod[i]   = t_reg[i] * m_reg[i];
            rs[i]     = {r_reg[i], q_reg[i][COORD_W-1]};
            ge[i]     = (rs[i] >= {1'b0, d_reg[i]});
            rs_sub[i] = rs[i] - {1'b0, d_reg[i]};
            rnd[i]    = neg_reg[i] ? ({r_reg[i], 1'b0} > {1'b0, d_reg[i]})
                                   : ({r_reg[i], 1'b0} >= {1'b0, d_reg[i]});
            qmag[i]   = {1'b0, q_reg[i]} + (COORD_W+1)'(rnd[i]);
            xv[i]     = neg_reg[i] ? ROW_W'(lo_x_reg[i]) - ROW_W'(qmag[i])
                                   : ROW_W'(lo_x_reg[i]) + ROW_W'(qmag[i]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        emit_row   = row_reg;
        emit_a     = xv[0];
        emit_b     = xv[1];
        emit_last  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (link.valid)
                begin
                    state_next = link.data.degen ? S_LAST : S_FIRST;
                end
            end
            S_FIRST:
            begin
                emit_row = ROW_W'(tri_reg.t_y);
                emit_a   = ROW_W'(tri_reg.t_x);
                emit_b   = tri_reg.flat_top ? ROW_W'(tri_reg.m_x) : ROW_W'(tri_reg.t_x);
                if (can_emit)
                begin
                    load_out   = 1'b1;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                if (row_reg > b_y_ext && cnt_reg != CNT_W'(MAX_SPANS - 1))
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_LAST;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(COORD_W - 1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (can_emit)
                begin
                    load_out   = 1'b1;
                    state_next = S_ROW;
                end
            end
            S_LAST:
            begin
                emit_row  = ROW_W'(tri_reg.b_y);
                emit_a    = ROW_W'(tri_reg.b_x);
                emit_b    = tri_reg.flat_bot ? ROW_W'(tri_reg.m_x) : ROW_W'(tri_reg.b_x);
                emit_last = 1'b1;
                if (can_emit)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (link_pop)
            begin
                cnt_reg  <= '0;
                drop_reg <= 1'b0;
            end
            else if (load_out)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == S_ROW && row_reg > b_y_ext
                && cnt_reg == CNT_W'(MAX_SPANS - 1))
            begin
                drop_reg <= 1'b1;
            end
            if (state_reg == S_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            else
            begin
                div_cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_pop)
        begin
            tri_reg <= link.data;
        end
        if (state_reg == S_FIRST)
        begin
            row_reg <= ROW_W'(tri_reg.t_y) - ROW_W'(step);
        end
        else if (state_reg == S_EMIT && can_emit)
        begin
            row_reg <= row_reg - ROW_W'(step);
        end
        for (int i = 0; i < 2; i++)
        begin
            if (state_reg == S_ROW)
            begin
                lo_x_reg[i] <= lo_x_s[i];
                d_reg[i]    <= dy_s[i][COORD_W-1:0];
                m_reg[i]    <= mag_s[i][COORD_W-1:0];
                t_reg[i]    <= t_s[i][COORD_W-1:0];
                neg_reg[i]  <= dx_s[i][COORD_W];
            end
            else if (state_reg == S_MUL)
            begin
                r_reg[i] <= prod[i][2*COORD_W-1:COORD_W];
                q_reg[i] <= prod[i][COORD_W-1:0];
            end
            else if (state_reg == S_DIV)
            begin
                r_reg[i] <= ge[i] ? rs_sub[i][COORD_W-1:0] : rs[i][COORD_W-1:0];
                q_reg[i] <= {q_reg[i][COORD_W-2:0], ge[i]};
            end
        end
        if (load_out)
        begin
            out_row_reg   <= emit_row[COORD_W-1:0];
            out_left_reg  <= (emit_a < emit_b) ? emit_a[COORD_W-1:0] : emit_b[COORD_W-1:0];
            out_right_reg <= (emit_a < emit_b) ? emit_b[COORD_W-1:0] : emit_a[COORD_W-1:0];
            out_color_reg <= tri_reg.color;
            out_last_reg  <= emit_last;
            out_cut_reg   <= emit_last && drop_reg;
        end
    end

    assign empty      = !out_valid_reg;
    assign span_row   = out_row_reg;
    assign span_left  = out_left_reg;
    assign span_right = out_right_reg;
    assign span_color = out_color_reg;
    assign last_span  = out_last_reg;
    assign cut_short  = out_cut_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_SPANS))
        else $error("span count past limit");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (r_reg[0] < d_reg[0]) && (r_reg[1] < d_reg[1]))
        else $error("divider remainder not reduced");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && emit_last) |=> (state_reg == S_IDLE))
        else $error("closing span did not end the triangle");

endmodule

// File: design/triangle_scanline_span_generator.sv
// Top level of the triangle scanline span generator.
// Usage:
// - Input queue: drive the three vertices and tri_color and raise push;
//   a transaction completes on a clock edge with push high and full low.
//   Two classified triangles can wait ahead of the span walker.
// - Output queue: while empty is low the oldest span is on the span ports;
//   pop takes it. A stalled receiver simply holds the span register and
//   the walker waits; nothing is lost.
// - Configuration: row_step is written by cfg_valid with cfg_ready, which
//   is always high. Write it only while no triangle is in flight.
// - Sequencing: with the walker idle, a transaction goes through the input
//   queue and the triangle register into the span register. Each interior
//   span passes ROW, MUL, DIV and EMIT; in DIV the 16-step serial dividers
//   interpolate both edges in parallel. The top span comes from FIRST and
//   the bottom span from LAST, then the walker is idle again; a degenerate
//   triangle skips to LAST. Stalls of the receiver also hold the walker.
// - Reset: rst_n clears both queues, the walker and sets row_step to 16.
module triangle_scanline_span_generator
    import tssg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [COORD_W-1:0] vertex_a_x,
    input  logic signed [COORD_W-1:0] vertex_a_y,
    input  logic signed [COORD_W-1:0] vertex_b_x,
    input  logic signed [COORD_W-1:0] vertex_b_y,
    input  logic signed [COORD_W-1:0] vertex_c_x,
    input  logic signed [COORD_W-1:0] vertex_c_y,
    input  logic [COLOR_W-1:0]        tri_color,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [COORD_W-1:0] span_row,
    output logic signed [COORD_W-1:0] span_left,
    output logic signed [COORD_W-1:0] span_right,
    output logic [COLOR_W-1:0]        span_color,
    output logic                      last_span,
    output logic                      cut_short,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [STEP_W-1:0]         row_step
);

    logic [STEP_W-1:0] row_step_reg;
    tri_link_t         link;
    logic              link_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_step_reg <= STEP_W'(STEP_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            row_step_reg <= row_step;
        end
    end

    tssg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .vertex_a_x (vertex_a_x),
        .vertex_a_y (vertex_a_y),
        .vertex_b_x (vertex_b_x),
        .vertex_b_y (vertex_b_y),
        .vertex_c_x (vertex_c_x),
        .vertex_c_y (vertex_c_y),
        .tri_color  (tri_color),
        .link       (link),
        .link_pop   (link_pop)
    );

    tssg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .link       (link),
        .link_pop   (link_pop),
        .row_step   (row_step_reg),
        .empty      (empty),
        .pop        (pop),
        .span_row   (span_row),
        .span_left  (span_left),
        .span_right (span_right),
        .span_color (span_color),
        .last_span  (last_span),
        .cut_short  (cut_short)
    );

endmodule
